### hdl/adc_channel_scan_sequencer_top_macros.svh
// Assertion macros for the ADC channel scan sequencer.
// Used by the checker module; needs no other file.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_TOP_MACROS_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_TOP_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define ACSS_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion on the block's own clock and reset.
`define ACSS_ASSERT(label, prop, msg) \
    `ACSS_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

### hdl/acss_pkg.sv
// Package for the ADC channel scan sequencer: payload structs, phase and
// command codes, register indexes and default sizes. No dependencies.
package acss_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int CODE_BITS_DEF    = 24;

    localparam int CH_W        = 4;
    localparam int PORT_CODE_W = 24;
    localparam int CNT_W       = 5;
    localparam int SETTLE_W    = 8;
    localparam int POLL_W      = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CNT_W-1:0]    CHANNEL_COUNT_RST = 5'd16;
    localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST  = 8'd8;
    localparam logic [POLL_W-1:0]   POLL_LIMIT_RST    = 10'd255;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT    = 2'd2;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ENTER_IR = 2'd1;
    localparam logic [1:0] CMD_TRIGGER  = 2'd2;
    localparam logic [1:0] CMD_RESTORE  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_OPEN    = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_TRIGGER = 3'd3,
        PH_READ_I  = 3'd4,
        PH_READ_V  = 3'd5,
        PH_CLOSE   = 3'd6,
        PH_PARKED  = 3'd7
    } phase_t;

    typedef struct packed {
        logic [1:0]             command;
        logic [CH_W-1:0]        ir_channel;
        logic                   current_ready;
        logic                   voltage_ready;
        logic [PORT_CODE_W-1:0] adc_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]             phase;
        logic                   mux_open_strobe;
        logic [CH_W-1:0]        mux_address;
        logic                   convert_strobe;
        logic                   read_current_strobe;
        logic                   read_voltage_strobe;
        logic                   sample_new;
        logic [CH_W-1:0]        sample_channel;
        logic [PORT_CODE_W-1:0] current_code;
        logic [PORT_CODE_W-1:0] voltage_code;
        logic                   adc_reset_strobe;
        logic                   ir_parked;
    } out_item_t;

endpackage

### hdl/adc_channel_scan_sequencer_top.sv
// ADC channel scan sequencer: the result of a transaction is registered and
// offered the cycle after it is accepted. Throughput one transaction per
// cycle; the output register accepts a new transaction while its current
// result is taken. aresetn is synchronous, active low: sequencer state,
// settings and the code stores clear at once, no sweep is needed.
module adc_channel_scan_sequencer_top
    import acss_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int CODE_BITS    = CODE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CNT_W-1:0]    channel_count_reg;
    logic [SETTLE_W-1:0] settle_ticks_reg;
    logic [POLL_W-1:0]   poll_limit_reg;

    phase_t              phase_reg, phase_next;
    logic [CH_W-1:0]     scan_channel_reg, scan_channel_next;
    logic [CH_W-1:0]     saved_channel_reg, saved_channel_next;
    logic [CH_W-1:0]     park_channel_reg, park_channel_next;
    logic                ir_mode_reg, ir_mode_next;
    logic                ir_switched_reg, ir_switched_next;
    logic                park_ready_reg, park_ready_next;
    logic [SETTLE_W-1:0] settle_count_reg, settle_count_next;
    logic [POLL_W-1:0]   poll_count_reg, poll_count_next;

    logic [CODE_BITS-1:0] current_store_reg [MAX_CHANNELS];
    logic [CODE_BITS-1:0] voltage_store_reg [MAX_CHANNELS];

    logic      m_valid_reg;
    out_item_t m_data_reg, m_data_next;

    logic                 accept;
    logic                 s_open, s_conv, s_ri, s_rv, s_new, s_rst;
    logic [CODE_BITS-1:0] code;
    logic                 wr_in_range, rd_in_range;
    logic                 cur_wr_en, volt_wr_en;
    logic [IDX_W-1:0]     wr_idx, rd_idx;
    logic [CODE_BITS-1:0] cur_rd, volt_rd;
    logic [CNT_W-1:0]     chan_inc;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign code     = CODE_BITS'(s_data.adc_data);
    assign chan_inc = {1'b0, scan_channel_reg} + CNT_W'(1);

    // Sequencer next state and strobes
    always_comb begin
        phase_next         = phase_reg;
        scan_channel_next  = scan_channel_reg;
        saved_channel_next = saved_channel_reg;
        park_channel_next  = park_channel_reg;
        ir_mode_next       = ir_mode_reg;
        ir_switched_next   = ir_switched_reg;
        park_ready_next    = park_ready_reg;
        settle_count_next  = settle_count_reg;
        poll_count_next    = poll_count_reg;
        s_open = 1'b0;
        s_conv = 1'b0;
        s_ri   = 1'b0;
        s_rv   = 1'b0;
        s_new  = 1'b0;
        s_rst  = 1'b0;
        unique case (s_data.command)
            CMD_ENTER_IR: begin
                saved_channel_next = scan_channel_reg;
                park_channel_next  = s_data.ir_channel;
                ir_mode_next       = 1'b1;
                park_ready_next    = 1'b0;
            end
            CMD_TRIGGER: begin
                phase_next = PH_TRIGGER;
            end
            CMD_RESTORE: begin
                scan_channel_next = saved_channel_reg;
                ir_mode_next      = 1'b0;
                phase_next        = PH_IDLE;
                ir_switched_next  = 1'b0;
            end
            default: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        phase_next        = PH_OPEN;
                        settle_count_next = '0;
                        scan_channel_next = '0;
                    end
                    PH_OPEN: begin
                        settle_count_next = '0;
                        phase_next        = PH_SETTLE;
                        if (ir_mode_reg) begin
                            ir_switched_next  = 1'b1;
                            scan_channel_next = park_channel_reg;
                        end
                        s_open = 1'b1;
                    end
                    PH_SETTLE: begin
                        settle_count_next = settle_count_reg + SETTLE_W'(1);
                        if (settle_count_next >= settle_ticks_reg) begin
                            phase_next = (ir_mode_reg && ir_switched_reg) ?
                                         PH_PARKED : PH_TRIGGER;
                            settle_count_next = '0;
                        end
                    end
                    PH_TRIGGER: begin
                        s_conv          = 1'b1;
                        poll_count_next = '0;
                        phase_next      = PH_READ_I;
                    end
                    PH_READ_I, PH_READ_V: begin
                        if (phase_reg == PH_READ_I && s_data.current_ready) begin
                            s_ri       = 1'b1;
                            phase_next = PH_READ_V;
                        end else if (phase_reg == PH_READ_V && s_data.voltage_ready) begin
                            s_rv       = 1'b1;
                            s_new      = (code != '0);
                            phase_next = PH_CLOSE;
                        end else begin
                            // Count the missed poll; give up past the limit
                            poll_count_next = poll_count_reg + POLL_W'(1);
                            if (poll_count_reg >= poll_limit_reg) begin
                                s_rst              = 1'b1;
                                phase_next         = PH_IDLE;
                                scan_channel_next  = '0;
                                saved_channel_next = '0;
                                ir_mode_next       = 1'b0;
                                ir_switched_next   = 1'b0;
                            end
                        end
                    end
                    PH_CLOSE: begin
                        if (!ir_mode_reg) begin
                            scan_channel_next = (chan_inc >= channel_count_reg) ?
                                                '0 : chan_inc[CH_W-1:0];
                            phase_next = PH_OPEN;
                        end else if (park_ready_reg) begin
                            phase_next = PH_PARKED;
                        end else begin
                            scan_channel_next = park_channel_reg;
                            phase_next        = PH_OPEN;
                        end
                    end
                    PH_PARKED: begin
                        park_ready_next = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // Store write on the current channel, read on the channel after the step
    assign wr_in_range = (int'(scan_channel_reg) < MAX_CHANNELS);
    assign rd_in_range = (int'(scan_channel_next) < MAX_CHANNELS);
    assign wr_idx      = IDX_W'(scan_channel_reg);
    assign rd_idx      = IDX_W'(scan_channel_next);
    assign cur_wr_en   = s_ri && (code != '0) && wr_in_range;
    assign volt_wr_en  = s_rv && (code != '0) && wr_in_range;

    // Forward a code written in this step to the read of the same channel
    always_comb begin
        cur_rd  = '0;
        volt_rd = '0;
        if (rd_in_range) begin
            cur_rd  = (cur_wr_en && scan_channel_reg == scan_channel_next) ?
                      code : current_store_reg[rd_idx];
            volt_rd = (volt_wr_en && scan_channel_reg == scan_channel_next) ?
                      code : voltage_store_reg[rd_idx];
        end
    end

    always_comb begin
        m_data_next.phase               = phase_next;
        m_data_next.mux_open_strobe     = s_open;
        m_data_next.mux_address         = scan_channel_next;
        m_data_next.convert_strobe      = s_conv;
        m_data_next.read_current_strobe = s_ri;
        m_data_next.read_voltage_strobe = s_rv;
        m_data_next.sample_new          = s_new;
        m_data_next.sample_channel      = scan_channel_next;
        m_data_next.current_code        = PORT_CODE_W'(cur_rd);
        m_data_next.voltage_code        = PORT_CODE_W'(volt_rd);
        m_data_next.adc_reset_strobe    = s_rst;
        m_data_next.ir_parked           = park_ready_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= CHANNEL_COUNT_RST;
            settle_ticks_reg  <= SETTLE_TICKS_RST;
            poll_limit_reg    <= POLL_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CNT_W-1:0];
                CFG_SETTLE_TICKS:  settle_ticks_reg  <= cfg_data[SETTLE_W-1:0];
                CFG_POLL_LIMIT:    poll_limit_reg    <= cfg_data[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            scan_channel_reg  <= '0;
            saved_channel_reg <= '0;
            park_channel_reg  <= '0;
            ir_mode_reg       <= 1'b0;
            ir_switched_reg   <= 1'b0;
            park_ready_reg    <= 1'b0;
            settle_count_reg  <= '0;
            poll_count_reg    <= '0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            scan_channel_reg  <= scan_channel_next;
            saved_channel_reg <= saved_channel_next;
            park_channel_reg  <= park_channel_next;
            ir_mode_reg       <= ir_mode_next;
            ir_switched_reg   <= ir_switched_next;
            park_ready_reg    <= park_ready_next;
            settle_count_reg  <= settle_count_next;
            poll_count_reg    <= poll_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                current_store_reg[i] <= '0;
                voltage_store_reg[i] <= '0;
            end
        end else if (accept) begin
            if (cur_wr_en) begin
                current_store_reg[wr_idx] <= code;
            end
            if (volt_wr_en) begin
                voltage_store_reg[wr_idx] <= code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

### hdl/acss_checker.sv
// Port-level checker for the ADC channel scan sequencer, bound to the top level.
// Depends on acss_pkg and adc_channel_scan_sequencer_top_macros.svh.
`include "adc_channel_scan_sequencer_top_macros.svh"

module acss_checker
    import acss_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Hold a stalled result
    `ACSS_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // Never overwrite a result that is not taken
    `ACSS_ASSERT(a_no_overrun, s_valid && s_ready && m_valid |-> m_ready, "transaction accepted over a pending result")

    `ACSS_ASSERT(a_timeout_idle, m_valid && m_data.adc_reset_strobe |-> m_data.phase == PH_IDLE, "poll timeout did not return to idle")

    `ACSS_ASSERT(a_new_on_read, m_valid && m_data.sample_new |-> m_data.read_voltage_strobe && m_data.phase == PH_CLOSE, "new sample without a voltage read")

endmodule

bind adc_channel_scan_sequencer_top acss_checker u_acss_checker (.*);
